// ===== rtl/mcuv_pkg.sv =====
// ----------------------------------------------------------------------------
// mcuv_pkg: shared types and constants of the matcap UV transform
// Request and result payloads, the tag that travels with each request
// through the pipeline, and the coefficient slot map.
// ----------------------------------------------------------------------------
package mcuv_pkg;

  localparam int FIELD_W     = 32;
  localparam int IDX_W       = 5;
  localparam int COEF_COUNT  = 24;
  localparam int BANK_SIZE   = 12;
  localparam int BANK_ADDR_W = 4;
  localparam int VIEW_BASE   = 12;

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          coef_index;
    logic signed [FIELD_W-1:0] coef_value;
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
  } mcuv_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] tex_u;
    logic signed [FIELD_W-1:0] tex_v;
    logic                      clipped;
  } mcuv_out_t;

  // per-request side information carried along the pipeline
  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic signed [FIELD_W-1:0] value;
    logic                      clip;
  } mcuv_tag_t;

endpackage

// ===== rtl/mcuv_coef_bank.sv =====
// ----------------------------------------------------------------------------
// mcuv_coef_bank: one matrix worth of coefficients
// Twelve registers holding a 3x3 matrix in column-major order followed by
// the translation column; all entries are presented in parallel.
// ----------------------------------------------------------------------------
module mcuv_coef_bank #(
  parameter int COEF_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [mcuv_pkg::BANK_ADDR_W-1:0]     wr_addr,
  input  logic signed [COEF_WIDTH-1:0]         wr_data,
  output logic signed [COEF_WIDTH-1:0]         mat_o   [3][3],
  output logic signed [COEF_WIDTH-1:0]         trans_o [3]
);

  logic signed [COEF_WIDTH-1:0] coef_r [mcuv_pkg::BANK_SIZE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcuv_pkg::BANK_SIZE; i++) begin
        coef_r[i] <= '0;
      end
    end else if (wr_en) begin
      coef_r[wr_addr] <= wr_data;
    end
  end

  // slot 3*c+r is row r of column c, slot 9+r the translation of row r
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat_o[r][c] = coef_r[3*c + r];
      end
      trans_o[r] = coef_r[9 + r];
    end
  end

endmodule

// ===== rtl/mcuv_xform_stage.sv =====
// ----------------------------------------------------------------------------
// mcuv_xform_stage: affine matrix-vector transform, two register stages
// Stage one forms split partial products of each coefficient with the
// vector; stage two sums them with the translation, rounds and saturates.
// ----------------------------------------------------------------------------
module mcuv_xform_stage #(
  parameter int COEF_WIDTH    = 32,
  parameter int VEC_WIDTH     = 32,
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  parameter int ROWS          = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mcuv_pkg::mcuv_tag_t                  in_tag_i,
  input  logic signed [VEC_WIDTH-1:0]          vec_i [3],
  input  logic                                 wr_hit_i,
  input  logic [mcuv_pkg::BANK_ADDR_W-1:0]     wr_addr_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mcuv_pkg::mcuv_tag_t                  out_tag_o,
  output logic signed [VALUE_WIDTH-1:0]        res_o [ROWS]
);

  localparam int SPLIT  = VEC_WIDTH / 2;
  localparam int HI_W   = VEC_WIDTH - SPLIT;
  localparam int PLO_W  = COEF_WIDTH + SPLIT + 1;
  localparam int PHI_W  = COEF_WIDTH + HI_W;
  localparam int ACC_W  = COEF_WIDTH + VEC_WIDTH + FRACTION_BITS + 3;
  localparam int SH_W   = ACC_W - FRACTION_BITS;
  localparam int CHK_W  = SH_W - VALUE_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [VALUE_WIDTH-1:0] SAT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] SAT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0] mat   [3][3];
  logic signed [COEF_WIDTH-1:0] trans [3];
  logic                         bank_we;

  logic                         p_ready, a_ready;
  logic                         p_valid_r, a_valid_r;
  mcuv_pkg::mcuv_tag_t          p_tag_r, a_tag_r, a_tag_nxt;
  logic signed [PLO_W-1:0]      plo_r [ROWS][3], plo_nxt [ROWS][3];
  logic signed [PHI_W-1:0]      phi_r [ROWS][3], phi_nxt [ROWS][3];
  logic signed [COEF_WIDTH-1:0] ptrans_r [ROWS], ptrans_nxt [ROWS];
  logic signed [ACC_W-1:0]      acc [ROWS];
  logic signed [SH_W-1:0]       sh  [ROWS];
  logic [CHK_W-1:0]             chk [ROWS];
  logic [ROWS-1:0]              ovf;
  logic signed [VALUE_WIDTH-1:0] res_r [ROWS], res_nxt [ROWS];

  // write a coefficient as its load request leaves the upstream register,
  // so requests ahead keep the old value and requests behind see the new one
  assign bank_we = in_valid_i && p_ready && (in_tag_i.op == mcuv_pkg::OP_LOAD) && wr_hit_i;

  mcuv_coef_bank #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bank_we),
    .wr_addr (wr_addr_i),
    .wr_data (in_tag_i.value[COEF_WIDTH-1:0]),
    .mat_o   (mat),
    .trans_o (trans)
  );

  // partial products: low half of each element unsigned, high half signed
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < 3; c++) begin
        plo_nxt[r][c] = mat[r][c] * $signed({1'b0, vec_i[c][SPLIT-1:0]});
        phi_nxt[r][c] = mat[r][c] * $signed(vec_i[c][VEC_WIDTH-1:SPLIT]);
      end
      ptrans_nxt[r] = trans[r];
    end
  end

  // sum, round half up, drop fraction bits, saturate
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      acc[r] = ACC_W'(ptrans_r[r]) <<< FRACTION_BITS;
      for (int c = 0; c < 3; c++) begin
        acc[r] = acc[r] + (ACC_W'(phi_r[r][c]) <<< SPLIT) + ACC_W'(plo_r[r][c]);
      end
      acc[r]     = acc[r] + HALF;
      sh[r]      = acc[r][ACC_W-1:FRACTION_BITS];
      chk[r]     = sh[r][SH_W-1:VALUE_WIDTH-1];
      ovf[r]     = !((&chk[r]) || !(|chk[r]));
      res_nxt[r] = ovf[r] ? (sh[r][SH_W-1] ? SAT_MIN : SAT_MAX) : sh[r][VALUE_WIDTH-1:0];
    end
    a_tag_nxt      = p_tag_r;
    a_tag_nxt.clip = p_tag_r.clip || (|ovf);
  end

  assign a_ready    = !a_valid_r || out_ready_i;
  assign p_ready    = !p_valid_r || a_ready;
  assign in_ready_o = p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_r <= in_valid_i;
      end
      if (a_ready) begin
        a_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready) begin
      p_tag_r  <= in_tag_i;
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
      ptrans_r <= ptrans_nxt;
    end
    if (a_ready) begin
      a_tag_r <= a_tag_nxt;
      res_r   <= res_nxt;
    end
  end

  assign out_valid_o = a_valid_r;
  assign out_tag_o   = a_tag_r;
  assign res_o       = res_r;

endmodule

// ===== rtl/mcuv_tex_out.sv =====
// ----------------------------------------------------------------------------
// mcuv_tex_out: texture coordinate mapping and output register
// Map view-space x and y to u = x/2 + 1/2 and v = -y/2 + 1/2, saturate,
// and hold the result until the consumer takes it. Load requests end here.
// ----------------------------------------------------------------------------
module mcuv_tex_out #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mcuv_pkg::mcuv_tag_t           in_tag_i,
  input  logic signed [VALUE_WIDTH-1:0] qx_i,
  input  logic signed [VALUE_WIDTH-1:0] qy_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mcuv_pkg::mcuv_out_t           out_data_o
);

  localparam int OUT_W = (VALUE_WIDTH < mcuv_pkg::FIELD_W) ? VALUE_WIDTH : mcuv_pkg::FIELD_W;
  localparam int TW    = ((VALUE_WIDTH > FRACTION_BITS + 1) ? VALUE_WIDTH : FRACTION_BITS + 1) + 3;
  localparam int CHK_W = TW - OUT_W + 1;
  localparam logic signed [TW-1:0] ONE = TW'(1) << FRACTION_BITS;
  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [TW-1:0]    su, sv, hu, hv;
  logic [CHK_W-1:0]        chk_u, chk_v;
  logic                    ovf_u, ovf_v;
  logic signed [OUT_W-1:0] u_sat, v_sat;
  logic                    out_valid_r;
  mcuv_pkg::mcuv_out_t     out_data_r, out_data_nxt;

  always_comb begin
    su    = TW'(qx_i) + ONE + TW'(1);
    sv    = -TW'(qy_i) + ONE + TW'(1);
    hu    = su >>> 1;
    hv    = sv >>> 1;
    chk_u = hu[TW-1:OUT_W-1];
    chk_v = hv[TW-1:OUT_W-1];
    ovf_u = !((&chk_u) || !(|chk_u));
    ovf_v = !((&chk_v) || !(|chk_v));
    u_sat = ovf_u ? (hu[TW-1] ? SAT_MIN : SAT_MAX) : hu[OUT_W-1:0];
    v_sat = ovf_v ? (hv[TW-1] ? SAT_MIN : SAT_MAX) : hv[OUT_W-1:0];
    out_data_nxt.tex_u   = mcuv_pkg::FIELD_W'(u_sat);
    out_data_nxt.tex_v   = mcuv_pkg::FIELD_W'(v_sat);
    out_data_nxt.clipped = in_tag_i.clip || ovf_u || ovf_v;
  end

  assign in_ready_o = !out_valid_r || !out_stall_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready_o) begin
      // drop load requests, only transforms give a result
      out_valid_r <= in_valid_i && (in_tag_i.op == mcuv_pkg::OP_XFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready_o) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

// ===== rtl/matcap_uv_transform_unit.sv =====
// ----------------------------------------------------------------------------
// matcap_uv_transform_unit: matcap texture coordinates from vertex normals
// Transform a normal by the model matrix, then the view matrix, and map
// view x/y to (u, v) in signed fixed point with saturation flagging.
// ----------------------------------------------------------------------------
// The unit takes one request per clock as long as the consumer keeps
// out_stall low; out_stall backs up through the pipeline one stage at a
// time, so empty stages are squeezed out before in_stall rises. A load
// request (op = OP_LOAD) writes one of the 24 coefficients and gives no
// result; it travels the pipeline in order with the transforms, so a
// transform accepted after a load always sees the new value and one
// accepted before never does. Loads and transforms may be mixed freely at
// full rate. Coefficient indexes 24..31 are ignored. Stages: input register
// with normal saturation, model partial products, model sum and round,
// view partial products, view sum and round, u/v mapping into the output
// register. Every multiply is split so that no single product exceeds
// 32 x 17 bits by default. clipped is set when any normal component, model
// row, view row x or y, u or v saturates. All coefficients reset to zero.
// ----------------------------------------------------------------------------
module matcap_uv_transform_unit #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcuv_pkg::mcuv_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcuv_pkg::mcuv_out_t out_data
);

  // coefficients and normals come from 32-bit fields, so never need more
  localparam int COEF_WIDTH = (VALUE_WIDTH < mcuv_pkg::FIELD_W) ? VALUE_WIDTH
                                                                : mcuv_pkg::FIELD_W;
  localparam int CHK_W = mcuv_pkg::FIELD_W - COEF_WIDTH + 1;
  localparam logic signed [COEF_WIDTH-1:0] SAT_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] SAT_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  // front saturation: three normal components and the load value
  logic signed [mcuv_pkg::FIELD_W-1:0] raw [4];
  logic [CHK_W-1:0]                    chk [4];
  logic [3:0]                          ovf;
  logic signed [COEF_WIDTH-1:0]        sat [4];

  // input register
  logic                         ready0;
  logic                         v0_r;
  mcuv_pkg::mcuv_tag_t          tag0_r, tag0_nxt;
  logic signed [COEF_WIDTH-1:0] n0_r [3], n0_nxt [3];

  // between stages
  logic                          m_in_ready, m_valid, v_in_ready, v_valid, t_in_ready;
  mcuv_pkg::mcuv_tag_t           m_tag, v_tag;
  logic                          m_hit, v_hit;
  logic [mcuv_pkg::BANK_ADDR_W-1:0] m_addr, v_addr;
  logic signed [VALUE_WIDTH-1:0] p [3];
  logic signed [VALUE_WIDTH-1:0] q [2];

  always_comb begin
    raw[0] = in_data.normal_x;
    raw[1] = in_data.normal_y;
    raw[2] = in_data.normal_z;
    raw[3] = in_data.coef_value;
    for (int i = 0; i < 4; i++) begin
      chk[i] = raw[i][mcuv_pkg::FIELD_W-1:COEF_WIDTH-1];
      ovf[i] = !((&chk[i]) || !(|chk[i]));
      sat[i] = ovf[i] ? (raw[i][mcuv_pkg::FIELD_W-1] ? SAT_MIN : SAT_MAX)
                      : raw[i][COEF_WIDTH-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      n0_nxt[i] = sat[i];
    end
    tag0_nxt.op    = in_data.op;
    tag0_nxt.idx   = in_data.coef_index;
    // saturate the stored value silently; only normals raise the flag
    tag0_nxt.value = mcuv_pkg::FIELD_W'(sat[3]);
    tag0_nxt.clip  = |ovf[2:0];
  end

  assign ready0   = !v0_r || m_in_ready;
  assign in_stall = !ready0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ready0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0) begin
      tag0_r <= tag0_nxt;
      n0_r   <= n0_nxt;
    end
  end

  // decode the coefficient slot into model or view bank
  assign m_hit  = tag0_r.idx < mcuv_pkg::IDX_W'(mcuv_pkg::BANK_SIZE);
  assign m_addr = tag0_r.idx[mcuv_pkg::BANK_ADDR_W-1:0];
  assign v_hit  = (m_tag.idx >= mcuv_pkg::IDX_W'(mcuv_pkg::VIEW_BASE)) &&
                  (m_tag.idx <  mcuv_pkg::IDX_W'(mcuv_pkg::COEF_COUNT));
  assign v_addr = mcuv_pkg::BANK_ADDR_W'(m_tag.idx - mcuv_pkg::IDX_W'(mcuv_pkg::VIEW_BASE));

  // model transform: all three rows
  mcuv_xform_stage #(
    .COEF_WIDTH    (COEF_WIDTH),
    .VEC_WIDTH     (COEF_WIDTH),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .ROWS          (3)
  ) u_model (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (v0_r),
    .in_ready_o  (m_in_ready),
    .in_tag_i    (tag0_r),
    .vec_i       (n0_r),
    .wr_hit_i    (m_hit),
    .wr_addr_i   (m_addr),
    .out_valid_o (m_valid),
    .out_ready_i (v_in_ready),
    .out_tag_o   (m_tag),
    .res_o       (p)
  );

  // view transform: rows x and y only, z never reaches the result
  mcuv_xform_stage #(
    .COEF_WIDTH    (COEF_WIDTH),
    .VEC_WIDTH     (VALUE_WIDTH),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .ROWS          (2)
  ) u_view (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (m_valid),
    .in_ready_o  (v_in_ready),
    .in_tag_i    (m_tag),
    .vec_i       (p),
    .wr_hit_i    (v_hit),
    .wr_addr_i   (v_addr),
    .out_valid_o (v_valid),
    .out_ready_i (t_in_ready),
    .out_tag_o   (v_tag),
    .res_o       (q)
  );

  mcuv_tex_out #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_tex (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (v_valid),
    .in_ready_o  (t_in_ready),
    .in_tag_i    (v_tag),
    .qx_i        (q[0]),
    .qy_i        (q[1]),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

endmodule

// ===== test/matcap_uv_checker.sv =====
// ----------------------------------------------------------------------------
// matcap_uv_checker: result predictor and scoreboard for the matcap UV unit
// Track the coefficient store from accepted load requests, compute the
// (u, v, clipped) result of every accepted transform request in wide signed
// arithmetic, and compare each accepted result field by field in order.
// ----------------------------------------------------------------------------
module matcap_uv_checker #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mcuv_pkg::mcuv_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mcuv_pkg::mcuv_out_t out_data,
  output int                  mismatch_count,
  output int                  results_owed
);

  typedef logic signed [127:0] wide_t;

  localparam int TEX_WIDTH = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  wide_t               coef_shadow [mcuv_pkg::COEF_COUNT];
  mcuv_pkg::mcuv_out_t uv_expected [$];
  mcuv_pkg::mcuv_out_t uv_want;
  int                  errors = 0;
  bit                  clip_seen;

  function automatic wide_t clamp(wide_t x, int w);
    wide_t hi_lim;
    hi_lim = (wide_t'(1) <<< (w - 1)) - 1;
    if (x > hi_lim) return hi_lim;
    if (x < -hi_lim - 1) return -hi_lim - 1;
    return x;
  endfunction

  // saturate and remember that something clipped
  function automatic wide_t sat_flagged(wide_t x, int w);
    wide_t y;
    y = clamp(x, w);
    if (y != x) clip_seen = 1'b1;
    return y;
  endfunction

  // exact row sum with translation, rounded once (add half, floor shift)
  function automatic wide_t row_round(int base, int row, wide_t v0, wide_t v1, wide_t v2);
    wide_t acc;
    acc = (coef_shadow[base + 9 + row] <<< FRACTION_BITS)
        + coef_shadow[base + row] * v0
        + coef_shadow[base + 3 + row] * v1
        + coef_shadow[base + 6 + row] * v2
        + (wide_t'(1) <<< (FRACTION_BITS - 1));
    return acc >>> FRACTION_BITS;
  endfunction

  task automatic apply_request(mcuv_pkg::mcuv_in_t req);
    wide_t               n0, n1, n2, p0, p1, p2, qx, qy, u, v, raw, one;
    mcuv_pkg::mcuv_out_t res;
    one = wide_t'(1) <<< FRACTION_BITS;
    if (req.op == mcuv_pkg::OP_LOAD) begin
      if (req.coef_index < mcuv_pkg::COEF_COUNT) begin
        raw = $signed(req.coef_value);
        coef_shadow[req.coef_index] = clamp(raw, VALUE_WIDTH);
      end
    end else begin
      clip_seen = 1'b0;
      n0 = $signed(req.normal_x);
      n1 = $signed(req.normal_y);
      n2 = $signed(req.normal_z);
      n0 = sat_flagged(n0, VALUE_WIDTH);
      n1 = sat_flagged(n1, VALUE_WIDTH);
      n2 = sat_flagged(n2, VALUE_WIDTH);
      p0 = sat_flagged(row_round(0, 0, n0, n1, n2), VALUE_WIDTH);
      p1 = sat_flagged(row_round(0, 1, n0, n1, n2), VALUE_WIDTH);
      p2 = sat_flagged(row_round(0, 2, n0, n1, n2), VALUE_WIDTH);
      qx = sat_flagged(row_round(mcuv_pkg::VIEW_BASE, 0, p0, p1, p2), VALUE_WIDTH);
      qy = sat_flagged(row_round(mcuv_pkg::VIEW_BASE, 1, p0, p1, p2), VALUE_WIDTH);
      u  = sat_flagged((qx + one + 1) >>> 1, TEX_WIDTH);
      v  = sat_flagged((-qy + one + 1) >>> 1, TEX_WIDTH);
      res.tex_u   = u[mcuv_pkg::FIELD_W-1:0];
      res.tex_v   = v[mcuv_pkg::FIELD_W-1:0];
      res.clipped = clip_seen;
      uv_expected.push_back(res);
    end
  endtask

  task automatic flag_field(string what, logic [mcuv_pkg::FIELD_W-1:0] want,
                            logic [mcuv_pkg::FIELD_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coef_shadow[i]) coef_shadow[i] = '0;
      uv_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (uv_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result: u=%h v=%h clipped=%b", $time,
                     out_data.tex_u, out_data.tex_v, out_data.clipped);
        end else begin
          uv_want = uv_expected.pop_front();
          if (out_data.tex_u !== uv_want.tex_u)
            flag_field("tex_u", uv_want.tex_u, out_data.tex_u);
          if (out_data.tex_v !== uv_want.tex_v)
            flag_field("tex_v", uv_want.tex_v, out_data.tex_v);
          if (out_data.clipped !== uv_want.clipped)
            flag_field("clipped", mcuv_pkg::FIELD_W'(uv_want.clipped),
                       mcuv_pkg::FIELD_W'(out_data.clipped));
        end
      end
      if (in_valid && !in_stall) apply_request(in_data);
    end
    mismatch_count <= errors;
    results_owed   <= uv_expected.size();
  end

endmodule

// ===== test/tb_matcap_uv_transform_unit.sv =====
// ----------------------------------------------------------------------------
// tb_matcap_uv_transform_unit: stimulus and verdict for the matcap UV unit
// Drive directed and random coefficient loads and normal transforms with
// random idling on both channels, a long result hold-off and a full drain
// pause; the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_matcap_uv_transform_unit;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 650;
  localparam int          HOLD_CYCLES  = 60;
  localparam logic [31:0] FX_ONE       = 32'h0001_0000;
  localparam logic [31:0] FX_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN       = 32'h8000_0000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mcuv_pkg::mcuv_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mcuv_pkg::mcuv_out_t out_data;

  int mismatches;
  int results_owed;
  int random_done;
  int watch_cycles = 0;
  int roll;

  // steady: no idling on either side; hold_results: ask the result side
  // for one long hold-off; hold_taken: the result side has served it
  bit steady       = 1'b0;
  bit hold_results = 1'b0;
  bit hold_taken   = 1'b0;

  always #4 clk = ~clk;

  matcap_uv_transform_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  matcap_uv_checker uv_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatches),
    .results_owed  (results_owed)
  );

  // Q16.16 value with a spread of magnitudes: unit-sized values dominate so
  // that chained products do not saturate all the time, but full-range and
  // extreme values show up as well.
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(4))
      0: return $urandom;
      1, 4: return $urandom_range(262143) - 131072;
      2: return $urandom_range(16777215) - 8388608;
      default: begin
        case ($urandom_range(4))
          0: return FX_MAX;
          1: return FX_MIN;
          2: return FX_ONE;
          3: return -FX_ONE;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // load request: the normal fields carry junk, the unit must ignore them
  function automatic mcuv_pkg::mcuv_in_t load_req(int idx, logic [31:0] val);
    mcuv_pkg::mcuv_in_t r;
    r.op         = mcuv_pkg::OP_LOAD;
    r.coef_index = idx[mcuv_pkg::IDX_W-1:0];
    r.coef_value = val;
    r.normal_x   = $urandom;
    r.normal_y   = $urandom;
    r.normal_z   = $urandom;
    return r;
  endfunction

  // transform request: the coefficient fields carry junk
  function automatic mcuv_pkg::mcuv_in_t xform_req(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
    mcuv_pkg::mcuv_in_t r;
    r.op         = mcuv_pkg::OP_XFORM;
    r.coef_index = mcuv_pkg::IDX_W'($urandom);
    r.coef_value = $urandom;
    r.normal_x   = x;
    r.normal_y   = y;
    r.normal_z   = z;
    return r;
  endfunction

  // Offer one request and hold it until accepted, then idle at random.
  // Exactly one nonblocking write to in_valid per time step: a back-to-back
  // request only raises valid again, it never lowers it first.
  task automatic send_request(input mcuv_pkg::mcuv_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      in_data  <= xform_req($urandom, $urandom, $urandom);
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request so the
  // pipeline fills and pushes back on the input channel.
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (hold_results && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 19);
      end
    end
  end

  // Hard stop in case the unit hangs.
  initial begin : watchdog
    while (watch_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      watch_cycles++;
    end
    $display("matcap_uv_transform_unit test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. All coefficients are zero after reset: extreme normals
    // must land on the center of the texture.
    send_request(xform_req(FX_MAX, FX_MIN, 32'h0));

    // Load identity rotation into both matrices.
    send_request(load_req(0, FX_ONE));
    send_request(load_req(4, FX_ONE));
    send_request(load_req(8, FX_ONE));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 0, FX_ONE));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 4, FX_ONE));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 8, FX_ONE));
    send_request(xform_req(FX_ONE, 32'h0, 32'h0));
    send_request(xform_req(32'h0, FX_ONE, 32'h0));
    send_request(xform_req(FX_MAX, FX_MAX, FX_MAX));
    send_request(xform_req(FX_MIN, FX_MIN, FX_MIN));

    // Indexes past the store: drop silently, identity must survive.
    send_request(load_req(31, 32'h0));
    send_request(load_req(24, FX_MAX));

    // Huge model coefficient: the model row saturates and sets clipped.
    send_request(load_req(3, FX_MAX));
    send_request(xform_req(FX_ONE, FX_ONE, 32'h0));

    // Extreme translations; view z translation must not matter.
    send_request(load_req(9, FX_MIN));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 9, FX_MAX));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 11, FX_MAX));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 1, -FX_ONE));
    send_request(xform_req(32'h0, 32'h0, 32'h0));
    send_request(xform_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // Clear slot 3 and the x translations again; exercise rounding at exact halves.
    send_request(load_req(3, 32'h0));
    send_request(load_req(9, 32'h0));
    send_request(load_req(mcuv_pkg::VIEW_BASE + 9, 32'h0));
    send_request(xform_req(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001));

    // Random part: mostly transforms over a slowly changing matrix.
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (random_done == 150) begin
        // hold results back while requests keep coming
        hold_results = 1'b1;
        steady       = 1'b1;
        repeat (30) send_request(xform_req(rand_q16(), rand_q16(), rand_q16()));
        steady       = 1'b0;
        random_done += 30;
      end
      if (random_done == 300) begin
        drain_results();
        repeat (8) @(posedge clk);
      end
      // long stretch with no idling at all
      steady = (random_done >= 420 && random_done < 520);

      roll = $urandom_range(99);
      if (roll < 68) begin
        send_request(xform_req(rand_q16(), rand_q16(), rand_q16()));
        random_done++;
      end else if (roll < 95) begin
        send_request(load_req($urandom_range(mcuv_pkg::COEF_COUNT - 1), rand_q16()));
        random_done++;
      end else begin
        // ignored index; does not count toward the random total
        send_request(load_req($urandom_range(31, mcuv_pkg::COEF_COUNT), $urandom));
      end
    end
    steady = 1'b0;

    // Let everything come back, then watch a little longer for strays.
    drain_results();
    repeat (12) @(posedge clk);

    if (mismatches == 0) begin
      $display("matcap_uv_transform_unit test passed");
    end else begin
      $display("matcap_uv_transform_unit test failed");
    end
    $finish;
  end

endmodule
